FILE: rtl/core/fdr_pkg.sv
`timescale 1ns / 1ps

package fdr_pkg;

    localparam int RING_DEPTH = 16;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_PREF     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_SIGNAL_MS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_DWELL_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOP_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPEAT_LEN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_FRAME_LEN  = 3'd6;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [3:0] CHAN_1  = 4'd1;
    localparam logic [3:0] CHAN_6  = 4'd6;
    localparam logic [3:0] CHAN_11 = 4'd11;
    localparam logic [3:0] CHAN_AUTO = 4'd0;

    localparam logic [31:0] AGE_BAR4_MS = 32'd500;
    localparam logic [31:0] AGE_BAR3_MS = 32'd1000;
    localparam logic [31:0] AGE_BAR2_MS = 32'd2000;

    typedef struct packed {
        logic capture;
        logic compare;
        logic commit;
    } fdr_cmd_t;

endpackage

FILE: rtl/core/fdr_ctrl.sv
`timescale 1ns / 1ps

module fdr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output fdr_pkg::fdr_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MATCH  = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       commit;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign commit   = (state_reg == ST_COMMIT) && (!out_valid_reg || m_tready);

    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.compare = (state_reg == ST_MATCH);
    assign cmd.commit  = commit;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_MATCH;
            end
            ST_MATCH: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (commit) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/core/fdr_dpath.sv
`timescale 1ns / 1ps

module fdr_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fdr_pkg::fdr_cmd_t                   cmd,
    input  logic                                in_opcode,
    input  logic [fdr_pkg::IN_DATA_W-1:0]       in_data,
    input  logic                                cfg_we,
    input  logic [fdr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fdr_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [fdr_pkg::OUT_DATA_W-1:0]      out_data
);

    // captured item
    logic        opcode_reg;
    logic [31:0] now_reg;
    logic        hdr_ok_reg;
    logic [7:0]  src_reg;
    logic [7:0]  seq_reg;
    logic [7:0]  hop_reg;
    logic        is_light_reg;
    logic [7:0]  flen_reg;
    logic        pay_ok_reg;

    // configuration
    logic        repeat_enable_reg;
    logic [3:0]  channel_pref_reg;
    logic [31:0] no_signal_ms_reg;
    logic [31:0] dwell_ms_reg;
    logic [7:0]  max_hop_reg;
    logic [7:0]  max_len_reg;
    logic [7:0]  light_len_reg;

    // link state
    logic [15:0]                 ring_reg [fdr_pkg::RING_DEPTH];
    logic [fdr_pkg::RING_AW-1:0] head_reg, head_next;
    logic                        heard_any_reg, heard_any_next;
    logic [31:0]                 last_rx_reg, last_rx_next;
    logic                        lost_reg, lost_next;
    logic [3:0]                  chan_reg, chan_next;
    logic [31:0]                 last_sw_reg, last_sw_next;

    // compare stage results
    logic [fdr_pkg::RING_DEPTH-1:0] match_reg;
    logic [31:0]                    age_reg;
    logic                           dwell_ok_reg;

    logic [15:0] key;
    logic [32:0] age_diff;
    logic [31:0] sw_diff;
    logic [3:0]  eff_pref;
    logic [3:0]  cfg_pref_eff;
    logic        age_lt_nsm;
    logic        age_gt_nsm;
    logic        is_frame;
    logic        dup;
    logic        unique_frame;
    logic        rep;
    logic [7:0]  rhop;
    logic        light;
    logic        lost_trig;
    logic        sw;
    logic        record;
    logic [2:0]  bars;

    function automatic logic [3:0] pref_of(input logic [3:0] p);
        logic [3:0] r;
        r = fdr_pkg::CHAN_AUTO;
        if (p == fdr_pkg::CHAN_1 || p == fdr_pkg::CHAN_6 || p == fdr_pkg::CHAN_11) begin
            r = p;
        end
        return r;
    endfunction

    assign key          = {src_reg, seq_reg};
    assign eff_pref     = pref_of(channel_pref_reg);
    assign cfg_pref_eff = pref_of(cfg_data[3:0]);

    // compare stage: ring match, frame age, dwell elapsed
    assign age_diff = {1'b0, now_reg} - {1'b0, last_rx_reg};
    assign sw_diff  = now_reg - last_sw_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            opcode_reg   <= in_opcode;
            now_reg      <= in_data[31:0];
            hdr_ok_reg   <= in_data[32];
            src_reg      <= in_data[40:33];
            seq_reg      <= in_data[48:41];
            hop_reg      <= in_data[56:49];
            is_light_reg <= in_data[57];
            flen_reg     <= in_data[65:58];
            pay_ok_reg   <= in_data[66];
        end
        if (cmd.compare) begin
            for (int i = 0; i < fdr_pkg::RING_DEPTH; i++) begin
                match_reg[i] <= (ring_reg[i] == key);
            end
            age_reg      <= age_diff[32] ? 32'd0 : age_diff[31:0];
            dwell_ok_reg <= (sw_diff >= dwell_ms_reg);
        end
    end

    // commit stage
    assign is_frame     = (opcode_reg == fdr_pkg::OP_FRAME);
    assign age_lt_nsm   = (age_reg < no_signal_ms_reg);
    assign age_gt_nsm   = !age_lt_nsm && (age_reg != no_signal_ms_reg);
    assign dup          = is_frame && hdr_ok_reg && (seq_reg != 8'd0) && (|match_reg);
    assign unique_frame = is_frame && hdr_ok_reg && !dup;
    assign record       = unique_frame && (seq_reg != 8'd0);
    assign rep          = unique_frame && repeat_enable_reg && (hop_reg < max_hop_reg)
                          && (flen_reg <= max_len_reg);
    assign rhop         = rep ? (hop_reg + 8'd1) : 8'd0;
    assign light        = unique_frame && is_light_reg && (flen_reg == light_len_reg)
                          && pay_ok_reg;
    assign lost_trig    = !is_frame && heard_any_reg && !lost_reg && age_gt_nsm;
    assign sw           = !is_frame && !lost_trig && (eff_pref == fdr_pkg::CHAN_AUTO)
                          && (!heard_any_reg || lost_reg) && dwell_ok_reg;

    always_comb begin
        if (is_frame) begin
            bars = 3'd4;
        end else if (!heard_any_reg) begin
            bars = 3'd0;
        end else if (age_reg < fdr_pkg::AGE_BAR4_MS) begin
            bars = 3'd4;
        end else if (age_reg < fdr_pkg::AGE_BAR3_MS) begin
            bars = 3'd3;
        end else if (age_reg < fdr_pkg::AGE_BAR2_MS) begin
            bars = 3'd2;
        end else if (age_lt_nsm) begin
            bars = 3'd1;
        end else begin
            bars = 3'd0;
        end
    end

    always_comb begin
        head_next      = head_reg;
        heard_any_next = heard_any_reg;
        last_rx_next   = last_rx_reg;
        lost_next      = lost_reg;
        chan_next      = chan_reg;
        last_sw_next   = last_sw_reg;
        if (cfg_we && cfg_index == fdr_pkg::CFG_CHANNEL_PREF) begin
            chan_next = (cfg_pref_eff == fdr_pkg::CHAN_AUTO) ? fdr_pkg::CHAN_11 : cfg_pref_eff;
        end
        if (cmd.commit) begin
            if (is_frame) begin
                heard_any_next = 1'b1;
                last_rx_next   = now_reg;
                lost_next      = 1'b0;
                if (record) begin
                    if (head_reg == fdr_pkg::RING_AW'(fdr_pkg::RING_DEPTH - 1)) begin
                        head_next = '0;
                    end else begin
                        head_next = head_reg + fdr_pkg::RING_AW'(1);
                    end
                end
            end else if (lost_trig) begin
                lost_next    = 1'b1;
                last_sw_next = now_reg;
            end else if (sw) begin
                chan_next    = (chan_reg == fdr_pkg::CHAN_11) ? fdr_pkg::CHAN_1
                                                              : fdr_pkg::CHAN_11;
                last_sw_next = now_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_enable_reg <= 1'b0;
            channel_pref_reg  <= fdr_pkg::CHAN_AUTO;
            no_signal_ms_reg  <= 32'd3000;
            dwell_ms_reg      <= 32'd2000;
            max_hop_reg       <= 8'd3;
            max_len_reg       <= 8'd250;
            light_len_reg     <= 8'd16;
        end else if (cfg_we) begin
            case (cfg_index)
                fdr_pkg::CFG_REPEAT_ENABLE:    repeat_enable_reg <= cfg_data[0];
                fdr_pkg::CFG_CHANNEL_PREF:     channel_pref_reg  <= cfg_data[3:0];
                fdr_pkg::CFG_NO_SIGNAL_MS:     no_signal_ms_reg  <= cfg_data;
                fdr_pkg::CFG_CHANNEL_DWELL_MS: dwell_ms_reg      <= cfg_data;
                fdr_pkg::CFG_MAX_HOP_COUNT:    max_hop_reg       <= cfg_data[7:0];
                fdr_pkg::CFG_MAX_REPEAT_LEN:   max_len_reg       <= cfg_data[7:0];
                fdr_pkg::CFG_LIGHT_FRAME_LEN:  light_len_reg     <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fdr_pkg::RING_DEPTH; i++) begin
                ring_reg[i] <= 16'd0;
            end
            head_reg      <= '0;
            heard_any_reg <= 1'b0;
            last_rx_reg   <= 32'd0;
            lost_reg      <= 1'b0;
            chan_reg      <= fdr_pkg::CHAN_11;
            last_sw_reg   <= 32'd0;
        end else begin
            if (cmd.commit && record) begin
                ring_reg[head_reg] <= key;
            end
            head_reg      <= head_next;
            heard_any_reg <= heard_any_next;
            last_rx_reg   <= last_rx_next;
            lost_reg      <= lost_next;
            chan_reg      <= chan_next;
            last_sw_reg   <= last_sw_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_data <= {3'd0, bars, sw, chan_next, lost_trig, lost_next, light, rhop, rep, dup};
        end
    end

endmodule

FILE: rtl/core/frame_dedup_repeater_link_monitor.sv
`timescale 1ns / 1ps

// Link supervisor for a broadcast lighting radio receiver. Each input item is a
// decoded frame header (s_tuser 0) or a millisecond tick (s_tuser 1); each gives
// exactly one result item with duplicate, repeat, light-command, signal-loss,
// channel-scan and signal-bar outputs. An item passes through capture, a compare
// step that checks the key against all ring entries in parallel and forms the frame
// age and dwell check, and a commit step that updates the ring and link state and
// loads the output register. Commit waits while the output register still holds
// an untaken result; the next item is accepted as soon as commit is done. The
// duplicate ring is cleared by reset itself, so no clearing pass follows reset.
// Configuration writes on cfg_we/cfg_index/cfg_data belong between items only.

module frame_dedup_repeater_link_monitor (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms, header_ok, src_id, seq_num, hops,
    // is_light_command, frame_len, payload_ok
    input  logic [fdr_pkg::IN_DATA_W-1:0]      s_tdata,
    // opcode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // is_duplicate, repeat_now, repeat_hop, light_ready, no_signal,
    // signal_lost_edge, listen_channel, channel_switched, age_bars
    output logic [fdr_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_we,
    input  logic [fdr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fdr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    fdr_pkg::fdr_cmd_t cmd;

    fdr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fdr_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_opcode (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata)
    );

endmodule
